/* hw/rtl/lfsrn_pkg.sv */
// Shared constants and types for the LFSR noise generator.
package lfsrn_pkg;

	localparam int REG_WIDTH = 32;
	localparam int POS_W     = $clog2(REG_WIDTH);
	localparam int CNT_W     = 24;
	localparam int FBPOS_W   = 5;
	localparam int SEED_W    = 2;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [FBPOS_W-1:0] FBPOS_RESET = FBPOS_W'(14);
	localparam logic [FBPOS_W-1:0] FBPOS_MAX   = FBPOS_W'(REG_WIDTH - 1);
	localparam logic [FBPOS_W-1:0] FBPOS_MIN   = FBPOS_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_POSITION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_MODE         = 1'b1;

	localparam logic [SEED_W-1:0] SEED_ALL_ONES = 2'd0;
	localparam logic [SEED_W-1:0] SEED_BELOW_FB = 2'd1;
	localparam logic [SEED_W-1:0] SEED_ONE      = 2'd2;

	localparam logic signed [1:0] LEVEL_POS = 2'sb01;
	localparam logic signed [1:0] LEVEL_NEG = 2'sb11;

	typedef struct packed {
		logic [REG_WIDTH-1:0] shift_reg;
		logic [CNT_W-1:0]     countdown;
		logic                 prev_trig;
		logic                 level_bit;
	} lfsrn_state_t;

endpackage

/* hw/rtl/lfsrn_step.sv */
// Next-state logic for one sample tick: countdown, reseed and LFSR step.
module lfsrn_step import lfsrn_pkg::*; (
	input  lfsrn_state_t        cur,
	input  logic [CNT_W-1:0]    step_period,
	input  logic                trig_high,
	input  logic [FBPOS_W-1:0]  feedback_position,
	input  logic [SEED_W-1:0]   seed_mode,
	output lfsrn_state_t        nxt
);

	logic [FBPOS_W-1:0]   pos_clip;
	logic [POS_W-1:0]     pos;
	logic [REG_WIDTH-1:0] seed;
	logic [REG_WIDTH-1:0] loaded;
	logic [REG_WIDTH-1:0] shifted;
	logic                 fb;
	logic                 reseed;
	logic                 fire;

	always_comb begin
		if (feedback_position < FBPOS_MIN) begin
			pos_clip = FBPOS_MIN;
		end else if (feedback_position > FBPOS_MAX) begin
			pos_clip = FBPOS_MAX;
		end else begin
			pos_clip = feedback_position;
		end
		pos = pos_clip[POS_W-1:0];
	end

	always_comb begin
		case (seed_mode)
			SEED_ALL_ONES: seed = '1;
			SEED_BELOW_FB: begin
				for (int i = 0; i < REG_WIDTH; i++) begin
					seed[i] = (POS_W'(i) < pos);
				end
			end
			default: seed = REG_WIDTH'(1);
		endcase
	end

	always_comb begin
		fire    = (cur.countdown == '0);
		reseed  = (cur.shift_reg == '0) || (trig_high && !cur.prev_trig);
		loaded  = reseed ? seed : cur.shift_reg;
		fb      = loaded[0] ^ loaded[1];
		shifted = loaded >> 1;
		shifted[pos] = fb;

		nxt = cur;
		if (fire) begin
			nxt.shift_reg = shifted;
			nxt.prev_trig = trig_high;
			nxt.level_bit = shifted[0];
			nxt.countdown = (step_period == '0) ? '0 : step_period - CNT_W'(1);
		end else begin
			nxt.countdown = cur.countdown - CNT_W'(1);
		end
	end

endmodule

/* hw/rtl/lfsr_noise_generator_top.sv */
// LFSR noise generator: one +1/-1 level per sample tick.
// An input transfer's result is registered straight into the output register.
// Throughput: one tick per cycle while in_stall is low; the step logic sits between state and result registers.
// in_stall rises only while a result waits and out_stall is high.
// Reset (arst_n low) loads an all-ones register, zero countdown, trigger low,
// feedback position 14 and seed mode 0, and empties the output register.
module lfsr_noise_generator_top import lfsrn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CNT_W-1:0]     step_period,
	input  logic                 trig_high,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [1:0]    level,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	lfsrn_state_t         state_q;
	lfsrn_state_t         state_nxt;
	logic [FBPOS_W-1:0]   feedback_position_q;
	logic [SEED_W-1:0]    seed_mode_q;
	logic                 out_valid_q;
	logic signed [1:0]    level_q;
	logic                 in_xfer;

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	lfsrn_step u_step (
		.cur               (state_q),
		.step_period       (step_period),
		.trig_high         (trig_high),
		.feedback_position (feedback_position_q),
		.seed_mode         (seed_mode_q),
		.nxt               (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_position_q <= FBPOS_RESET;
			seed_mode_q         <= SEED_ALL_ONES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FEEDBACK_POSITION: feedback_position_q <= cfg_data[FBPOS_W-1:0];
				CFG_SEED_MODE:         seed_mode_q         <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.shift_reg <= '1;
			state_q.countdown <= '0;
			state_q.prev_trig <= 1'b0;
			state_q.level_bit <= 1'b0;
		end else if (in_xfer) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			level_q <= state_nxt.level_bit ? LEVEL_POS : LEVEL_NEG;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

endmodule

/* hw/rtl/lfsrn_checker.sv */
// Port-level checks for the LFSR noise generator, bound to the top level.
module lfsrn_checker import lfsrn_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic signed [1:0]    level
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level))
		else $error("stalled result changed");

	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level == LEVEL_POS || level == LEVEL_NEG))
		else $error("level is neither +1 nor -1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("input transfer produced no result");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result appeared without an input transfer");

endmodule

bind lfsr_noise_generator_top lfsrn_checker u_lfsrn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.level     (level)
);
